// ===== hw/rtl/mandelbrot_escape_time_unit_assert.svh =====
// Assertion macros for the escape-time unit.
`ifndef MANDELBROT_ESCAPE_TIME_UNIT_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset.
`define MET_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("met assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define MET_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("met assertion failed");

`else

`define MET_ASSERT(label, clk, rst, prop)
`define MET_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/met_pkg.sv =====
package met_pkg;

   localparam int FRACTION_BITS = 26;
   localparam int INT_BITS      = 6;
   localparam int FIX_W         = FRACTION_BITS + INT_BITS;
   localparam int PROD_W        = 2 * FIX_W;
   localparam int SUM_W         = PROD_W + 2;
   localparam int MAG_W         = PROD_W + 1;

   localparam int INDEX_W     = 11;
   localparam int STEP_W      = 26;
   localparam int LIMIT_W     = 6;
   localparam int COUNT_W     = 6;
   localparam int GLYPH_W     = 7;
   localparam int CPROD_W     = INDEX_W + STEP_W + 1;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [STEP_W-1:0]  COLUMN_STEP_RESET = 26'd3073586;
   localparam logic [STEP_W-1:0]  ROW_STEP_RESET    = 26'd5592182;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET       = 6'd16;

   // |z|^2 > 4 at full product scale
   localparam logic [MAG_W-1:0] ESCAPE_BOUND = MAG_W'(1) << (2 * FRACTION_BITS + 2);

   localparam logic [GLYPH_W-1:0] GLYPH_SPACE      = 7'd32;
   localparam logic [GLYPH_W-1:0] GLYPH_ZERO       = 7'd48;
   localparam logic [GLYPH_W-1:0] GLYPH_LETTER_GAP = 7'd7;
   localparam logic [COUNT_W-1:0] GLYPH_DIGIT_MAX  = 6'd9;

   typedef logic signed [FIX_W-1:0] fix_type;
   typedef logic signed [SUM_W-1:0] sum_type;

   localparam fix_type FIX_MAX = fix_type'({1'b0, {(FIX_W-1){1'b1}}});
   localparam fix_type FIX_MIN = fix_type'({1'b1, {(FIX_W-1){1'b0}}});

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COLUMN_STEP     = 2'd0,
      CSR_ROW_STEP        = 2'd1,
      CSR_ITERATION_LIMIT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic load;
      logic step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic finish;
   } status_type;

   function automatic fix_type saturate(input sum_type v);
      logic [SUM_W-FIX_W:0] upper;
      upper = v[SUM_W-1:FIX_W-1];
      if ((&upper) || !(|upper)) begin
         return fix_type'(v[FIX_W-1:0]);
      end else if (v[SUM_W-1]) begin
         return FIX_MIN;
      end else begin
         return FIX_MAX;
      end
   endfunction

   function automatic logic [GLYPH_W-1:0] glyph_of(input logic hit,
                                                   input logic [COUNT_W-1:0] cnt);
      logic [GLYPH_W-1:0] g;
      g = GLYPH_ZERO + GLYPH_W'(cnt);
      if (cnt > GLYPH_DIGIT_MAX) begin
         g = g + GLYPH_LETTER_GAP;
      end
      if (!hit) begin
         g = GLYPH_SPACE;
      end
      return g;
   endfunction

endpackage

// ===== hw/rtl/met_datapath.sv =====
module met_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  met_pkg::cmd_type                 cmd,
   output met_pkg::status_type              status,
   input  logic [met_pkg::INDEX_W-1:0]      column_index,
   input  logic [met_pkg::INDEX_W-1:0]      row_index,
   input  logic [met_pkg::STEP_W-1:0]       column_step,
   input  logic [met_pkg::STEP_W-1:0]       row_step,
   input  logic [met_pkg::LIMIT_W-1:0]      iteration_limit,
   output logic                             escaped,
   output logic [met_pkg::COUNT_W-1:0]      escape_count,
   output logic [met_pkg::GLYPH_W-1:0]      glyph
);

   localparam int EXT_W = met_pkg::SUM_W - met_pkg::PROD_W;
   localparam int FEXT_W = met_pkg::SUM_W - met_pkg::FIX_W;
   localparam int CEXT_W = met_pkg::SUM_W - met_pkg::CPROD_W;

   met_pkg::fix_type a_ff, a_in;
   met_pkg::fix_type b_ff, b_in;
   met_pkg::fix_type ca_ff, ca_in;
   met_pkg::fix_type cb_ff, cb_in;
   logic [met_pkg::LIMIT_W-1:0] step_ff, step_in;

   logic                        escaped_ff, escaped_in;
   logic [met_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [met_pkg::GLYPH_W-1:0] glyph_ff, glyph_in;

   logic signed [met_pkg::CPROD_W-1:0] col_prod, row_prod;
   logic signed [met_pkg::PROD_W-1:0]  aa, bb, ab;
   logic [met_pkg::MAG_W-1:0]          mag;
   met_pkg::sum_type                   re, im, ca_x, cb_x;
   logic                               hit;
   logic [met_pkg::COUNT_W-1:0]        hit_count;

   // c = index * step, saturated to the fixed-point range
   assign col_prod = $signed(column_index) * $signed({1'b0, column_step});
   assign row_prod = $signed(row_index) * $signed({1'b0, row_step});

   assign aa = a_ff * a_ff;
   assign bb = b_ff * b_ff;
   assign ab = a_ff * b_ff;

   assign mag = {1'b0, aa} + {1'b0, bb};
   assign hit = (step_ff != '0) && (mag > met_pkg::ESCAPE_BOUND);

   assign ca_x = met_pkg::sum_type'({{FEXT_W{ca_ff[met_pkg::FIX_W-1]}}, ca_ff})
                 <<< met_pkg::FRACTION_BITS;
   assign cb_x = met_pkg::sum_type'({{FEXT_W{cb_ff[met_pkg::FIX_W-1]}}, cb_ff})
                 <<< met_pkg::FRACTION_BITS;

   assign re = met_pkg::sum_type'({{EXT_W{aa[met_pkg::PROD_W-1]}}, aa})
             - met_pkg::sum_type'({{EXT_W{bb[met_pkg::PROD_W-1]}}, bb})
             + ca_x;
   assign im = (met_pkg::sum_type'({{EXT_W{ab[met_pkg::PROD_W-1]}}, ab}) <<< 1) + cb_x;

   assign hit_count = step_ff - met_pkg::COUNT_W'(1);

   assign status.hit    = hit;
   assign status.finish = hit || (step_ff == iteration_limit);

   always_comb begin
      a_in       = a_ff;
      b_in       = b_ff;
      ca_in      = ca_ff;
      cb_in      = cb_ff;
      step_in    = step_ff;
      escaped_in = escaped_ff;
      count_in   = count_ff;
      glyph_in   = glyph_ff;
      if (cmd.load) begin
         ca_in   = met_pkg::saturate(met_pkg::sum_type'(
                      {{CEXT_W{col_prod[met_pkg::CPROD_W-1]}}, col_prod}));
         cb_in   = met_pkg::saturate(met_pkg::sum_type'(
                      {{CEXT_W{row_prod[met_pkg::CPROD_W-1]}}, row_prod}));
         a_in    = ca_in;
         b_in    = cb_in;
         step_in = '0;
      end else if (cmd.step) begin
         a_in    = met_pkg::saturate(re >>> met_pkg::FRACTION_BITS);
         b_in    = met_pkg::saturate(im >>> met_pkg::FRACTION_BITS);
         step_in = step_ff + met_pkg::LIMIT_W'(1);
      end
      if (cmd.emit) begin
         escaped_in = hit;
         count_in   = hit ? hit_count : '0;
         glyph_in   = met_pkg::glyph_of(hit, hit_count);
      end
   end

   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      b_ff       <= b_in;
      ca_ff      <= ca_in;
      cb_ff      <= cb_in;
      step_ff    <= step_in;
      escaped_ff <= escaped_in;
      count_ff   <= count_in;
      glyph_ff   <= glyph_in;
   end

   assign escaped      = escaped_ff;
   assign escape_count = count_ff;
   assign glyph        = glyph_ff;

`include "mandelbrot_escape_time_unit_assert.svh"

   `MET_ASSERT(a_step_below_limit, clock, reset, !cmd.step || (step_ff < iteration_limit))
   `MET_ASSERT_NEXT(a_emit_hit_flag, clock, reset, cmd.emit && hit, escaped_ff)

endmodule

// ===== hw/rtl/met_controller.sv =====
module met_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output met_pkg::cmd_type    cmd,
   input  met_pkg::status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign cmd.load = req_tvalid && req_tready;
   assign cmd.step = (state_ff == ST_RUN) && !status.finish;
   assign cmd.emit = (state_ff == ST_RUN) && status.finish && out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (cmd.emit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

`include "mandelbrot_escape_time_unit_assert.svh"

   `MET_ASSERT_NEXT(a_load_starts_run, clock, reset, cmd.load, state_ff == ST_RUN)
   `MET_ASSERT_NEXT(a_emit_shows_word, clock, reset, cmd.emit, rsp_valid_ff)
   `MET_ASSERT_NEXT(a_blocked_result_held, clock, reset,
                    (state_ff == ST_RUN) && status.finish && !out_free,
                    (state_ff == ST_RUN) && rsp_valid_ff)

endmodule

// ===== hw/rtl/mandelbrot_escape_time_unit.sv =====
// Channel   Dir   Ports          Word contents (low bit first)
// req       in    req_t*         column_index[10:0], row_index[21:11], zero pad
// rsp       out   rsp_t*         escaped[0], escape_count[6:1], glyph[13:7], zero pad
// csr       in    csr_*          0 column_step, 1 row_step, 2 iteration_limit
//
// One pixel at a time: accept loads c, then one z update per cycle on three
// parallel 32x32 multipliers; the result is registered once the limit is reached
// or on early escape; the next word can be taken once the result is registered.
// Synchronous active-high reset clears control state and restores csr defaults.
// A result blocked on rsp_tready holds the engine; req_tready stays low meanwhile.
module mandelbrot_escape_time_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [met_pkg::REQ_DATA_W-1:0]      req_tdata,   // column_index, row_index
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [met_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // escaped, escape_count, glyph
   input  logic                                csr_we,
   input  logic [met_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [met_pkg::STEP_W-1:0]          csr_wdata
);

   localparam int PAD_W = met_pkg::RSP_DATA_W - 1 - met_pkg::COUNT_W - met_pkg::GLYPH_W;

   logic [met_pkg::STEP_W-1:0]  column_step_ff, column_step_in;
   logic [met_pkg::STEP_W-1:0]  row_step_ff, row_step_in;
   logic [met_pkg::LIMIT_W-1:0] limit_ff, limit_in;

   met_pkg::cmd_type    cmd;
   met_pkg::status_type status;

   logic                        escaped;
   logic [met_pkg::COUNT_W-1:0] escape_count;
   logic [met_pkg::GLYPH_W-1:0] glyph;

   always_comb begin
      column_step_in = column_step_ff;
      row_step_in    = row_step_ff;
      limit_in       = limit_ff;
      if (csr_we) begin
         case (csr_index)
            met_pkg::CSR_COLUMN_STEP:     column_step_in = csr_wdata;
            met_pkg::CSR_ROW_STEP:        row_step_in    = csr_wdata;
            met_pkg::CSR_ITERATION_LIMIT: limit_in       = csr_wdata[met_pkg::LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_step_ff <= met_pkg::COLUMN_STEP_RESET;
         row_step_ff    <= met_pkg::ROW_STEP_RESET;
         limit_ff       <= met_pkg::LIMIT_RESET;
      end else begin
         column_step_ff <= column_step_in;
         row_step_ff    <= row_step_in;
         limit_ff       <= limit_in;
      end
   end

   met_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   met_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .column_index    (req_tdata[met_pkg::INDEX_W-1:0]),
      .row_index       (req_tdata[2*met_pkg::INDEX_W-1:met_pkg::INDEX_W]),
      .column_step     (column_step_ff),
      .row_step        (row_step_ff),
      .iteration_limit (limit_ff),
      .escaped         (escaped),
      .escape_count    (escape_count),
      .glyph           (glyph)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, glyph, escape_count, escaped};

endmodule

// ===== verif/mandelbrot_escape_time_unit_test.sv =====
module mandelbrot_escape_time_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import met_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam logic signed [127:0] FIX_HI = (128'sd1 <<< (FIX_W - 1)) - 128'sd1;
   localparam logic signed [127:0] FIX_LO = -FIX_HI - 128'sd1;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_PIXELS = 150;

   typedef struct packed {
      logic                escaped;
      logic [COUNT_W-1:0]  count;
      logic [GLYPH_W-1:0]  glyph;
   } pixel_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [STEP_W-1:0]       csr_wdata = '0;

   // local copy of the register file
   logic [STEP_W-1:0]   col_step   = COLUMN_STEP_RESET;
   logic [STEP_W-1:0]   row_step   = ROW_STEP_RESET;
   logic [LIMIT_W-1:0]  iter_limit = LIMIT_RESET;

   pixel_result_type pending_pixels[$];
   int            mismatch_count = 0;
   bit            req_idle = 1'b1;
   bit            rsp_idle = 1'b1;
   int unsigned   rsp_long_hold = 0;

   mandelbrot_escape_time_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic logic signed [127:0] clamp_fix(input logic signed [127:0] v);
      if (v > FIX_HI) begin
         return FIX_HI;
      end else if (v < FIX_LO) begin
         return FIX_LO;
      end
      return v;
   endfunction

   function automatic pixel_result_type escape_time_of(input logic signed [INDEX_W-1:0] col,
                                                       input logic signed [INDEX_W-1:0] row);
      logic signed [127:0] ca, cb, a, b, re, im, s, bound;
      pixel_result_type r;
      int i;
      ca = 128'(col);
      s = 128'(col_step);
      ca = clamp_fix(ca * s);
      cb = 128'(row);
      s = 128'(row_step);
      cb = clamp_fix(cb * s);
      a = ca;
      b = cb;
      bound = 128'sd1 <<< (2 * FRACTION_BITS + 2);
      r.escaped = 1'b0;
      r.count = '0;
      r.glyph = GLYPH_SPACE;
      for (i = 0; i < int'(iter_limit); i++) begin
         re = a * a - b * b + (ca <<< FRACTION_BITS);
         im = ((a * b) <<< 1) + (cb <<< FRACTION_BITS);
         a = clamp_fix(re >>> FRACTION_BITS);
         b = clamp_fix(im >>> FRACTION_BITS);
         if (a * a + b * b > bound) begin
            r.escaped = 1'b1;
            r.count = COUNT_W'(i);
            r.glyph = GLYPH_ZERO + GLYPH_W'(i)
                    + ((i > int'(GLYPH_DIGIT_MAX)) ? GLYPH_LETTER_GAP : '0);
            return r;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("%0t: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
   endtask

   // result checker
   always @(posedge clock) begin : check_words
      pixel_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("unexpected word", 1, 0);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_tdata[0] !== want.escaped)
               report_mismatch("escaped", int'(rsp_tdata[0]), int'(want.escaped));
            if (rsp_tdata[6:1] !== want.count)
               report_mismatch("escape_count", int'(rsp_tdata[6:1]), int'(want.count));
            if (rsp_tdata[13:7] !== want.glyph)
               report_mismatch("glyph", int'(rsp_tdata[13:7]), int'(want.glyph));
         end
      end
   end

   // receiver: random stalls per word while rsp_idle is set, plus an occasional long hold-off
   initial begin : drive_rsp_ready
      int unsigned n;
      forever begin
         n = rsp_idle ? $urandom_range(0, 9) : 0;
         if (rsp_long_hold > 0) begin
            n = rsp_long_hold;
            rsp_long_hold = 0;
         end
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   task automatic send_pixel(input int col, input int row);
      logic signed [INDEX_W-1:0] col_w, row_w;
      int unsigned gap;
      col_w = INDEX_W'(col);
      row_w = INDEX_W'(row);
      gap = req_idle ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_W'({row_w, col_w});
      do @(posedge clock); while (!req_tready);
      pending_pixels.push_back(escape_time_of(col_w, row_w));
   endtask

   task automatic drain_pixels();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [STEP_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_COLUMN_STEP:     col_step = val;
         CSR_ROW_STEP:        row_step = val;
         CSR_ITERATION_LIMIT: iter_limit = val[LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   // index spread so that each part of c mostly lands within +/-2.5
   function automatic int pick_index(input logic [STEP_W-1:0] step);
      int span;
      if ($urandom_range(0, 3) == 0) begin
         return int'($urandom_range(0, 2047)) - 1024;
      end
      span = (step == '0) ? 1023 : 167772160 / int'(step);
      if (span > 1023) span = 1023;
      if (span < 1) span = 1;
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   task automatic test_reset_settings();
      send_pixel(0, 0);
      send_pixel(1023, 1023);
      send_pixel(-1024, -1024);
      send_pixel(-1024, 1023);
      send_pixel(1023, -1024);
      send_pixel(-40, 0);
      send_pixel(5, 3);
      drain_pixels();
   endtask

   task automatic test_step_extremes();
      csr_write(CSR_COLUMN_STEP, '1);
      csr_write(CSR_ROW_STEP, '0);
      csr_write(CSR_ITERATION_LIMIT, STEP_W'(36));
      send_pixel(1, 0);
      send_pixel(-1, 0);
      send_pixel(0, 1023);
      drain_pixels();
      csr_write(CSR_COLUMN_STEP, '0);
      csr_write(CSR_ROW_STEP, '1);
      send_pixel(0, -1);
      send_pixel(0, 1);
      drain_pixels();
   endtask

   task automatic test_limit_extremes();
      csr_write(CSR_COLUMN_STEP, 26'd1 << 20);
      csr_write(CSR_ROW_STEP, 26'd1 << 20);
      csr_write(CSR_ITERATION_LIMIT, STEP_W'(0));
      send_pixel(1023, 1023);
      send_pixel(0, 0);
      drain_pixels();
      csr_write(CSR_ITERATION_LIMIT, STEP_W'(63));
      send_pixel(-48, 0);
      send_pixel(16, 40);
      send_pixel(0, 0);
      drain_pixels();
      // unmapped index must leave the registers alone
      csr_write(CSR_UNMAPPED, STEP_W'($urandom));
      csr_write(CSR_ITERATION_LIMIT, {20'hFFFFF, 6'd1});
      send_pixel(100, 20);
      send_pixel(-30, 5);
      send_pixel(-100, -1);
      drain_pixels();
   endtask

   task automatic test_random_phases();
      int p, k;
      logic [LIMIT_W-1:0] lim;
      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       lim = 6'd1;
            1:       lim = 6'd36;
            2:       lim = 6'd63;
            default: lim = LIMIT_W'($urandom_range(1, 36));
         endcase
         csr_write(CSR_ITERATION_LIMIT, {(STEP_W - LIMIT_W)'($urandom), lim});
         if (p == 3) begin
            csr_write(CSR_COLUMN_STEP, '1);
            csr_write(CSR_ROW_STEP, '1);
         end else begin
            csr_write(CSR_COLUMN_STEP, STEP_W'($urandom_range(1 << 18, 1 << 23)));
            csr_write(CSR_ROW_STEP, STEP_W'($urandom_range(1 << 18, 1 << 23)));
         end
         req_idle = (p % 4 != 1);
         rsp_idle = (p % 4 != 2);
         for (k = 0; k < PHASE_PIXELS; k++) begin
            send_pixel(pick_index(col_step), pick_index(row_step));
         end
         drain_pixels();
      end
      req_idle = 1'b1;
      rsp_idle = 1'b1;
   endtask

   task automatic test_backpressure();
      int k;
      csr_write(CSR_COLUMN_STEP, COLUMN_STEP_RESET);
      csr_write(CSR_ROW_STEP, ROW_STEP_RESET);
      csr_write(CSR_ITERATION_LIMIT, STEP_W'(LIMIT_RESET));
      req_idle = 1'b0;
      rsp_long_hold = 300;
      for (k = 0; k < 24; k++) begin
         send_pixel(pick_index(col_step), pick_index(row_step));
      end
      drain_pixels();
      req_idle = 1'b1;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_settings();
      test_step_extremes();
      test_limit_extremes();
      test_random_phases();
      test_backpressure();
      drain_pixels();
      repeat (80) @(posedge clock);
      if (pending_pixels.size() != 0) begin
         report_mismatch("leftover words", pending_pixels.size(), 0);
      end
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
